/* src/vlc_pkg.sv */
// Shared types and constants of the vehicle lighting controller.
// Used by vlc_front, vlc_fifo, vlc_back and vehicle_lighting_controller.
`timescale 1ns / 1ps

package vlc_pkg;

  localparam int unsigned NumLevels = 9;
  localparam int unsigned NumMsgs   = 9;
  localparam int unsigned MaxMsgs   = 5;
  localparam int unsigned FifoDepth = 2;

  // Reset values of the configuration registers.
  localparam logic [15:0] BrakeOnReset     = 16'd100;
  localparam logic [15:0] BrakePeriodReset = 16'd1000;
  localparam logic [7:0]  BlinkPerReset    = 8'd50;
  localparam logic [19:0] LockoutReset     = 20'd65536;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    RegBrakeOn     = 2'd0,
    RegBrakePeriod = 2'd1,
    RegBlinkPer    = 2'd2,
    RegLockout     = 2'd3
  } reg_idx_e;

  // Message codes; a code is also the bit position in the message mask.
  typedef enum logic [3:0] {
    MsgHead    = 4'd0,
    MsgHazard  = 4'd1,
    MsgLeft    = 4'd2,
    MsgRight   = 4'd3,
    MsgBrake   = 4'd4,
    MsgStarter = 4'd5,
    MsgHorn    = 4'd6,
    MsgAuxA    = 4'd7,
    MsgAuxB    = 4'd8
  } msg_code_e;

  // Bit positions of the button levels in a tick word.
  localparam int unsigned LvlHorn    = 0;
  localparam int unsigned LvlHazard  = 1;
  localparam int unsigned LvlAuxA    = 2;
  localparam int unsigned LvlLeft    = 3;
  localparam int unsigned LvlStarter = 4;
  localparam int unsigned LvlHead    = 5;
  localparam int unsigned LvlAuxB    = 6;
  localparam int unsigned LvlRight   = 7;
  localparam int unsigned LvlBrake   = 8;

  typedef struct packed {
    logic [15:0] brake_on_ticks;
    logic [15:0] brake_period_ticks;
    logic [7:0]  blink_periods;
    logic [19:0] lockout_ticks;
  } vlc_cfg_t;

  // One classified tick: light outputs and the messages it raises.
  typedef struct packed {
    logic [NumMsgs-1:0] msg_vals;
    logic [NumMsgs-1:0] msg_mask;
    logic [7:0]         lights;
  } vlc_rec_t;

endpackage

/* src/vlc_front.sv */
// Front end: accepts tick words, updates timers, modes and lockout,
// and classifies each tick into a record for the queue. Uses vlc_pkg.
`timescale 1ns / 1ps

module vlc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vlc_pkg::vlc_cfg_t              cfg_i,
  input  logic                           valid_i,
  input  logic [vlc_pkg::NumLevels-1:0]  levels_i,
  output logic                           ready_o,
  output logic                           push_o,
  output vlc_pkg::vlc_rec_t              rec_o,
  input  logic                           full_i
);
  import vlc_pkg::*;

  logic [NumLevels-1:0] prev_q, prev_d;
  logic [15:0]          timer_q, timer_d;
  logic                 dim_q, dim_d;
  logic [7:0]           bcount_q, bcount_d;
  logic                 bphase_q, bphase_d;
  logic [3:0]           mode_q, mode_d;
  logic                 locked_q, locked_d;
  logic [19:0]          rem_q, rem_d;

  logic [NumLevels-1:0] cur, fall, change;
  logic [NumMsgs-1:0]   mask, vals;
  logic [2:0]           n_msgs;
  logic                 tog_hit;
  logic [1:0]           tog_idx;
  logic [7:0]           bcount_t;
  logic                 brake, hz, dash_l, dash_r, l_left, l_right, l_brake;
  logic                 accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept;

  always_comb begin
    cur    = levels_i;
    fall   = prev_q & ~cur;
    change = prev_q ^ cur;
    mask   = '0;
    vals   = '0;
    mode_d = mode_q;

    // Lockout countdown at the start of the tick.
    locked_d = locked_q;
    rem_d    = rem_q;
    if (locked_q) begin
      if (rem_q <= 20'd1) begin
        locked_d = 1'b0;
        rem_d    = '0;
      end else begin
        rem_d = rem_q - 20'd1;
      end
    end

    // Period timer, dim phase and blink counter.
    dim_d    = dim_q;
    bcount_t = bcount_q;
    timer_d  = timer_q + 16'd1;
    if (timer_q < cfg_i.brake_on_ticks) begin
      dim_d = 1'b1;
    end else if (timer_q > cfg_i.brake_period_ticks) begin
      bcount_t = bcount_q + 8'd1;
      timer_d  = '0;
    end else begin
      dim_d = 1'b0;
    end
    bcount_d = bcount_t;
    bphase_d = bphase_q;
    if (bcount_t > cfg_i.blink_periods) begin
      bphase_d = ~bphase_q;
      bcount_d = '0;
    end

    // Only the first toggle in code order counts; it locks out the others.
    tog_hit = 1'b0;
    tog_idx = 2'd0;
    if (!locked_d) begin
      if (fall[LvlHead]) begin
        tog_hit = 1'b1;
        tog_idx = 2'd0;
      end else if (fall[LvlHazard]) begin
        tog_hit = 1'b1;
        tog_idx = 2'd1;
      end else if (fall[LvlLeft]) begin
        tog_hit = 1'b1;
        tog_idx = 2'd2;
      end else if (fall[LvlRight]) begin
        tog_hit = 1'b1;
        tog_idx = 2'd3;
      end
    end
    if (tog_hit) begin
      mode_d[tog_idx]                  = ~mode_q[tog_idx];
      mask[{2'b00, tog_idx}]           = 1'b1;
      vals[{2'b00, tog_idx}]           = ~mode_q[tog_idx];
      locked_d                         = 1'b1;
      rem_d                            = cfg_i.lockout_ticks;
      if (tog_idx != 2'd0) begin
        bphase_d = 1'b1;
        bcount_d = '0;
      end
    end

    mask[MsgBrake]   = change[LvlBrake];
    vals[MsgBrake]   = cur[LvlBrake];
    mask[MsgStarter] = change[LvlStarter];
    vals[MsgStarter] = cur[LvlStarter];
    mask[MsgHorn]    = change[LvlHorn];
    vals[MsgHorn]    = cur[LvlHorn];

    // Releasing the starter or horn starts a lockout unless one runs.
    if ((fall[LvlStarter] || fall[LvlHorn]) && !locked_d) begin
      locked_d = 1'b1;
      rem_d    = cfg_i.lockout_ticks;
    end

    n_msgs = {2'b00, tog_hit} + {2'b00, change[LvlBrake]} +
             {2'b00, change[LvlStarter]} + {2'b00, change[LvlHorn]};
    if (change[LvlAuxA] && !locked_d) begin
      mask[MsgAuxA] = 1'b1;
      vals[MsgAuxA] = cur[LvlAuxA];
      n_msgs        = n_msgs + 3'd1;
    end
    if (change[LvlAuxB] && !locked_d && (n_msgs < 3'(MaxMsgs))) begin
      mask[MsgAuxB] = 1'b1;
      vals[MsgAuxB] = cur[LvlAuxB];
    end

    brake   = cur[LvlBrake];
    hz      = mode_d[1];
    l_brake = mode_d[0] ? (brake | dim_d) : brake;
    dash_l  = brake;
    dash_r  = mode_d[0];
    l_left  = 1'b0;
    l_right = 1'b0;
    if (hz) begin
      l_left  = bphase_d;
      dash_l  = bphase_d;
      l_right = bphase_d;
      dash_r  = bphase_d;
    end else begin
      if (mode_d[2]) begin
        l_left = bphase_d;
        dash_l = bphase_d;
      end
      if (mode_d[3]) begin
        l_right = bphase_d;
        dash_r  = bphase_d;
      end
    end

    prev_d          = cur;
    rec_o.lights    = {cur[LvlHorn], cur[LvlStarter], dash_r, dash_l,
                       l_right, l_left, l_brake, mode_d[0]};
    rec_o.msg_mask  = mask;
    rec_o.msg_vals  = vals;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      timer_q  <= '0;
      dim_q    <= 1'b0;
      bcount_q <= '0;
      bphase_q <= 1'b0;
      mode_q   <= '0;
      locked_q <= 1'b0;
      rem_q    <= '0;
    end else if (accept) begin
      prev_q   <= prev_d;
      timer_q  <= timer_d;
      dim_q    <= dim_d;
      bcount_q <= bcount_d;
      bphase_q <= bphase_d;
      mode_q   <= mode_d;
      locked_q <= locked_d;
      rem_q    <= rem_d;
    end
  end

endmodule

/* src/vlc_fifo.sv */
// Short record queue between the front end and the back end.
// Uses vlc_pkg for the record type and depth.
`timescale 1ns / 1ps

module vlc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vlc_pkg::vlc_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output vlc_pkg::vlc_rec_t rec_o
);
  import vlc_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  vlc_rec_t          mem_q [FifoDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("record pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("record popped from an empty queue");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(FifoDepth))
    else $error("queue count beyond depth");

endmodule

/* src/vlc_back.sv */
// Back end: takes records from the queue and sends their messages one word
// per cycle while not stalled, through an output register. Uses vlc_pkg.
`timescale 1ns / 1ps

module vlc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  vlc_pkg::vlc_rec_t rec_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [7:0]        lights_o,
  output logic              msg_valid_o,
  output logic [3:0]        msg_code_o,
  output logic              msg_value_o,
  output logic              last_o
);
  import vlc_pkg::*;

  logic                 cur_valid_q, cur_valid_d;
  vlc_rec_t             cur_q, cur_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_lights_q, out_lights_d;
  logic                 out_msg_q, out_msg_d;
  msg_code_e            out_code_q, out_code_d;
  logic                 out_val_q, out_val_d;
  logic                 out_last_q, out_last_d;

  logic                 advance, beat_last;
  logic [NumMsgs-1:0]   rest;
  msg_code_e            low_code;

  assign advance = !out_valid_q || ready_i;

  always_comb begin
    low_code = MsgHead;
    for (int i = NumMsgs - 1; i >= 0; i--) begin
      if (cur_q.msg_mask[i]) begin
        low_code = msg_code_e'(4'(i));
      end
    end
    rest      = cur_q.msg_mask & (cur_q.msg_mask - 1'b1);
    beat_last = (rest == '0);
  end

  always_comb begin
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    out_valid_d  = out_valid_q;
    out_lights_d = out_lights_q;
    out_msg_d    = out_msg_q;
    out_code_d   = out_code_q;
    out_val_d    = out_val_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    if (advance) begin
      out_valid_d = cur_valid_q;
      if (cur_valid_q) begin
        // A tick with no messages still sends one word, marked quiet.
        out_lights_d = cur_q.lights;
        out_msg_d    = (cur_q.msg_mask != '0);
        out_code_d   = low_code;
        out_val_d    = cur_q.msg_vals[low_code] & out_msg_d;
        out_last_d   = beat_last;
        cur_d.msg_mask = rest;
        if (beat_last) begin
          cur_valid_d = 1'b0;
        end
      end
    end
    if (!cur_valid_d && !empty_i) begin
      pop_o       = 1'b1;
      cur_valid_d = 1'b1;
      cur_d       = rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    out_lights_q <= out_lights_d;
    out_msg_q    <= out_msg_d;
    out_code_q   <= out_code_d;
    out_val_q    <= out_val_d;
    out_last_q   <= out_last_d;
  end

  assign valid_o     = out_valid_q;
  assign lights_o    = out_lights_q;
  assign msg_valid_o = out_msg_q;
  assign msg_code_o  = out_code_q;
  assign msg_value_o = out_val_q;
  assign last_o      = out_last_q;

  a_quiet_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_msg_q) |-> out_last_q)
    else $error("quiet word not marked last");

  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_msg_q) |-> (out_code_q <= MsgAuxB))
    else $error("message code out of range");

  a_pop_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!cur_valid_q || (advance && beat_last)))
    else $error("record loaded over one still in progress");

endmodule

/* src/vehicle_lighting_controller.sv */
// Top level of the vehicle lighting controller: configuration registers,
// front end, record queue and back end. Uses vlc_pkg and the vlc_* modules.
//
//  Channel   Dir  Payload                                       Moves on
//  s_axis    in   tdata: 9 button levels, horn in bit 0         tvalid & tready
//  m_axis    out  tdata: lights, msg_value; tuser: msg_valid,   tvalid & tready
//                 msg_code; tlast: last word of a tick
//  apb       in   four 32-bit registers at 0x0, 0x4, 0x8, 0xC   psel & penable
//
// A tick word is classified in the cycle it is accepted; each tick then yields
// one output word per message, at most five, or one word for a quiet tick,
// sent one word per cycle by the back end's output register while not stalled.
// Reset clears control state and presets the config; then ticks can be taken.
// A two-entry record queue lets ticks be accepted while the output stalls.
`timescale 1ns / 1ps

module vehicle_lighting_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // bit 0 horn, 1 hazard, 2 aux a, 3 left turn, 4 starter, 5 headlight,
  // 6 aux b, 7 right turn, 8 brake switch, 15:9 zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bits 7:0 lights, 8 msg_value, 15:9 zero
  output logic [15:0] m_axis_tdata,
  // bit 0 msg_valid, bits 4:1 msg_code
  output logic [4:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vlc_pkg::*;

  vlc_cfg_t  cfg_q;
  reg_idx_e  reg_idx;
  logic      cfg_we;
  logic      push, full, pop, empty;
  vlc_rec_t  rec_in, rec_out;
  logic [7:0] lights;
  logic      msg_valid, msg_value;
  logic [3:0] msg_code;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_on_ticks     <= BrakeOnReset;
      cfg_q.brake_period_ticks <= BrakePeriodReset;
      cfg_q.blink_periods      <= BlinkPerReset;
      cfg_q.lockout_ticks      <= LockoutReset;
    end else if (cfg_we) begin
      case (reg_idx)
        RegBrakeOn:     cfg_q.brake_on_ticks     <= pwdata[15:0];
        RegBrakePeriod: cfg_q.brake_period_ticks <= pwdata[15:0];
        RegBlinkPer:    cfg_q.blink_periods      <= pwdata[7:0];
        RegLockout:     cfg_q.lockout_ticks      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegBrakeOn:     prdata = {16'd0, cfg_q.brake_on_ticks};
      RegBrakePeriod: prdata = {16'd0, cfg_q.brake_period_ticks};
      RegBlinkPer:    prdata = {24'd0, cfg_q.blink_periods};
      RegLockout:     prdata = {12'd0, cfg_q.lockout_ticks};
      default:        prdata = '0;
    endcase
  end

  vlc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (s_axis_tvalid),
    .levels_i (s_axis_tdata[NumLevels-1:0]),
    .ready_o  (s_axis_tready),
    .push_o   (push),
    .rec_o    (rec_in),
    .full_i   (full)
  );

  vlc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (rec_out)
  );

  vlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .lights_o    (lights),
    .msg_valid_o (msg_valid),
    .msg_code_o  (msg_code),
    .msg_value_o (msg_value),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, msg_value, lights};
  assign m_axis_tuser = {msg_code, msg_valid};

endmodule
